FILE: rtl/core/oxvc_pkg.sv
// Shared types and constants for the oxygen sensor line parser and valve control.
package oxvc_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_START   = 2'd1,
        CMD_STOP    = 2'd2,
        CMD_REQUEST = 2'd3
    } cmd_t;

    // config register indexes
    localparam logic REG_TEMP_LIMIT    = 1'b0;
    localparam logic REG_OXYGEN_TARGET = 1'b1;

    localparam logic signed [15:0] TEMP_LIMIT_RST    = 16'sd6000;
    localparam logic [15:0]        OXYGEN_TARGET_RST = 16'd5000;

    localparam logic [26:0] MAG_SAT = 27'd99999999;

    localparam logic [7:0] CH_SEP   = 8'h3B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] CH_AMP  = 8'h41;  // 'A'
    localparam logic [7:0] CH_PHA  = 8'h50;  // 'P'
    localparam logic [7:0] CH_TMP  = 8'h54;  // 'T'
    localparam logic [7:0] CH_OXY  = 8'h4F;  // 'O'
    localparam logic [7:0] CH_ERR  = 8'h45;  // 'E'

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    // parsed word from front to back
    typedef struct packed {
        cmd_t        cmd;
        logic        done;
        logic        ok;
        logic [23:0] amplitude;
        logic [15:0] phase;
        logic [15:0] temperature;
        logic [15:0] oxygen;
        logic [26:0] error_code;
    } parse_word_t;

    // result word
    typedef struct packed {
        logic        frame_done;
        logic        frame_ok;
        logic        valve_open;
        logic        system_on;
        logic        temp_trip;
        logic        sensor_fault;
        logic [15:0] oxygen;
        logic [15:0] temperature;
        logic [15:0] phase;
        logic [23:0] amplitude;
        logic [26:0] error_code;
    } result_word_t;

    // expected prefix letter of numeric field n (1..5)
    function automatic logic [7:0] prefix_char(input logic [2:0] n);
        logic [7:0] ch;
        case (n)
            3'd1:    ch = CH_AMP;
            3'd2:    ch = CH_PHA;
            3'd3:    ch = CH_TMP;
            3'd4:    ch = CH_OXY;
            default: ch = CH_ERR;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/core/oxygen_sensor_line_parser_valve_control_top.sv
// Top level of the oxygen sensor line parser and valve control block.
// Words go in through push/full and results come out through pop/empty, one result per
// input word, in order. Both sides take one word per clock while the queue they write is
// not full: the parser classifies each command/byte word in the cycle it is pushed and
// writes it into a small queue; the control stage drains that queue one word per cycle
// into the result queue. Results pass from the middle queue through the control stage
// into the result queue, whose head drives the result ports. MID_DEPTH and OUT_DEPTH set
// how many words each queue can buffer while the other side stalls. There is no start-up
// pass after reset. Config writes (wr_en/wr_index/wr_data) take effect at once and are
// meant for idle periods.
module oxygen_sensor_line_parser_valve_control_top #(
    parameter int MID_DEPTH = oxvc_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = oxvc_pkg::OUT_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         cmd,
    input  logic [7:0]         rx_byte,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [15:0]        wr_data,
    output logic               empty,
    input  logic               pop,
    output logic               frame_done,
    output logic               frame_ok,
    output logic               valve_open,
    output logic               system_on,
    output logic               temp_trip,
    output logic               sensor_fault,
    output logic [15:0]        oxygen,
    output logic signed [15:0] temperature,
    output logic [15:0]        phase,
    output logic [23:0]        amplitude,
    output logic [26:0]        error_code
);

    localparam int PW_BITS = $bits(oxvc_pkg::parse_word_t);
    localparam int RW_BITS = $bits(oxvc_pkg::result_word_t);

    oxvc_pkg::parse_word_t  pw_in, pw_out;
    oxvc_pkg::result_word_t rw_in, rw_out;
    logic [PW_BITS-1:0]     pw_out_bits;
    logic [RW_BITS-1:0]     rw_out_bits;
    logic                   accept;
    logic                   mid_empty;
    logic                   out_full;
    logic                   step;

    assign accept = push & ~full;
    assign step   = ~mid_empty & ~out_full;

    oxvc_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .cmd      (oxvc_pkg::cmd_t'(cmd)),
        .rx_byte  (rx_byte),
        .pw       (pw_in)
    );

    oxvc_fifo #(
        .WIDTH (PW_BITS),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (pw_in),
        .full  (full),
        .pop   (step),
        .rdata (pw_out_bits),
        .empty (mid_empty)
    );

    assign pw_out = oxvc_pkg::parse_word_t'(pw_out_bits);

    oxvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_valid (step),
        .pw       (pw_out),
        .rw       (rw_in)
    );

    oxvc_fifo #(
        .WIDTH (RW_BITS),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (step),
        .wdata (rw_in),
        .full  (out_full),
        .pop   (pop),
        .rdata (rw_out_bits),
        .empty (empty)
    );

    assign rw_out = oxvc_pkg::result_word_t'(rw_out_bits);

    assign frame_done   = rw_out.frame_done;
    assign frame_ok     = rw_out.frame_ok;
    assign valve_open   = rw_out.valve_open;
    assign system_on    = rw_out.system_on;
    assign temp_trip    = rw_out.temp_trip;
    assign sensor_fault = rw_out.sensor_fault;
    assign oxygen       = rw_out.oxygen;
    assign temperature  = rw_out.temperature;
    assign phase        = rw_out.phase;
    assign amplitude    = rw_out.amplitude;
    assign error_code   = rw_out.error_code;

endmodule

FILE: rtl/core/oxvc_fifo.sv
// Small synchronous word queue with push/full and pop/empty sides.
module oxvc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/core/oxvc_parser.sv
// Front end: takes command/byte words, parses sensor lines, emits parsed words.
module oxvc_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  oxvc_pkg::cmd_t        cmd,
    input  logic [7:0]            rx_byte,
    output oxvc_pkg::parse_word_t pw
);

    logic        request_open_reg, request_open_next;
    logic        line_started_reg, line_started_next;
    logic [2:0]  field_index_reg,  field_index_next;
    logic        first_reg,        first_next;
    logic        started_reg,      started_next;
    logic        neg_reg,          neg_next;
    logic        num_done_reg,     num_done_next;
    logic        prefix_ok_reg,    prefix_ok_next;
    logic [26:0] acc_reg,          acc_next;

    logic [23:0] amp_reg,  amp_next;
    logic [15:0] phase_reg, phase_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] oxy_reg,  oxy_next;

    // field values derived from the running magnitude
    logic [23:0] val_amp;
    logic [15:0] val_u16;
    logic [15:0] val_temp;
    logic [30:0] acc_mul;
    logic        is_digit, is_blank, is_sign, is_eol;
    logic        done, ok;

    assign val_amp  = neg_reg ? 24'd0 :
                      (acc_reg > 27'hFFFFFF) ? 24'hFFFFFF : acc_reg[23:0];
    assign val_u16  = neg_reg ? 16'd0 :
                      (acc_reg > 27'hFFFF) ? 16'hFFFF : acc_reg[15:0];
    assign val_temp = neg_reg ?
                      ((acc_reg > 27'd32768) ? 16'h8000 : 16'(16'd0 - acc_reg[15:0])) :
                      ((acc_reg > 27'd32767) ? 16'h7FFF : acc_reg[15:0]);

    assign is_digit = (rx_byte >= oxvc_pkg::CH_ZERO) && (rx_byte <= oxvc_pkg::CH_NINE);
    assign is_blank = (rx_byte == oxvc_pkg::CH_SP) || (rx_byte == oxvc_pkg::CH_TAB) ||
                      (rx_byte == oxvc_pkg::CH_VT) || (rx_byte == oxvc_pkg::CH_FF);
    assign is_sign  = (rx_byte == oxvc_pkg::CH_PLUS) || (rx_byte == oxvc_pkg::CH_MINUS);
    assign is_eol   = (rx_byte == oxvc_pkg::CH_CR) || (rx_byte == oxvc_pkg::CH_LF);

    // acc*10 + digit; never exceeds 31 bits since acc <= MAG_SAT
    assign acc_mul = {acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {27'd0, rx_byte[3:0]};

    always_comb
    begin
        request_open_next = request_open_reg;
        line_started_next = line_started_reg;
        field_index_next  = field_index_reg;
        first_next        = first_reg;
        started_next      = started_reg;
        neg_next          = neg_reg;
        num_done_next     = num_done_reg;
        prefix_ok_next    = prefix_ok_reg;
        acc_next          = acc_reg;
        amp_next          = amp_reg;
        phase_next        = phase_reg;
        temp_next         = temp_reg;
        oxy_next          = oxy_reg;
        done              = 1'b0;
        ok                = 1'b0;

        case (cmd)
            oxvc_pkg::CMD_BYTE:
            begin
                if (request_open_reg)
                begin
                    if (is_eol)
                    begin
                        if (line_started_reg)
                        begin
                            done = 1'b1;
                            ok   = (field_index_reg == 3'd5) && prefix_ok_reg && !first_reg;
                            request_open_next = 1'b0;
                            line_started_next = 1'b0;
                            field_index_next  = 3'd0;
                            first_next        = 1'b1;
                            started_next      = 1'b0;
                            neg_next          = 1'b0;
                            num_done_next     = 1'b0;
                            prefix_ok_next    = 1'b1;
                            acc_next          = '0;
                        end
                    end
                    else
                    begin
                        line_started_next = 1'b1;
                        if (rx_byte == oxvc_pkg::CH_SEP && field_index_reg < 3'd5)
                        begin
                            if (field_index_reg != 3'd0)
                            begin
                                if (first_reg)
                                begin
                                    // empty field
                                    prefix_ok_next = 1'b0;
                                end
                                else
                                begin
                                    case (field_index_reg)
                                        3'd1:    amp_next   = val_amp;
                                        3'd2:    phase_next = val_u16;
                                        3'd3:    temp_next  = val_temp;
                                        3'd4:    oxy_next   = val_u16;
                                        default: ;
                                    endcase
                                end
                            end
                            field_index_next = field_index_reg + 3'd1;
                            first_next       = 1'b1;
                            started_next     = 1'b0;
                            neg_next         = 1'b0;
                            num_done_next    = 1'b0;
                            acc_next         = '0;
                        end
                        else if (field_index_reg != 3'd0)
                        begin
                            if (first_reg)
                            begin
                                first_next = 1'b0;
                                if (rx_byte != oxvc_pkg::prefix_char(field_index_reg))
                                begin
                                    prefix_ok_next = 1'b0;
                                end
                            end
                            else if (!num_done_reg)
                            begin
                                if (is_digit)
                                begin
                                    started_next = 1'b1;
                                    acc_next = (acc_mul > 31'(oxvc_pkg::MAG_SAT)) ?
                                               oxvc_pkg::MAG_SAT : acc_mul[26:0];
                                end
                                else if (!started_reg && is_blank)
                                begin
                                    // leading blank skipped
                                end
                                else if (!started_reg && is_sign)
                                begin
                                    started_next = 1'b1;
                                    neg_next     = (rx_byte == oxvc_pkg::CH_MINUS);
                                end
                                else
                                begin
                                    num_done_next = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            oxvc_pkg::CMD_REQUEST:
            begin
                request_open_next = 1'b1;
                line_started_next = 1'b0;
                field_index_next  = 3'd0;
                first_next        = 1'b1;
                started_next      = 1'b0;
                neg_next          = 1'b0;
                num_done_next     = 1'b0;
                prefix_ok_next    = 1'b1;
                acc_next          = '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        pw.cmd         = cmd;
        pw.done        = done;
        pw.ok          = ok;
        pw.amplitude   = amp_reg;
        pw.phase       = phase_reg;
        pw.temperature = temp_reg;
        pw.oxygen      = oxy_reg;
        pw.error_code  = acc_reg;  // last field is the raw magnitude
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_open_reg <= 1'b0;
            line_started_reg <= 1'b0;
            field_index_reg  <= 3'd0;
            first_reg        <= 1'b1;
            started_reg      <= 1'b0;
            neg_reg          <= 1'b0;
            num_done_reg     <= 1'b0;
            prefix_ok_reg    <= 1'b1;
            acc_reg          <= '0;
        end
        else if (in_valid)
        begin
            request_open_reg <= request_open_next;
            line_started_reg <= line_started_next;
            field_index_reg  <= field_index_next;
            first_reg        <= first_next;
            started_reg      <= started_next;
            neg_reg          <= neg_next;
            num_done_reg     <= num_done_next;
            prefix_ok_reg    <= prefix_ok_next;
            acc_reg          <= acc_next;
        end
    end

    // staged fields: only read on a good line, where all are freshly written
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            amp_reg   <= amp_next;
            phase_reg <= phase_next;
            temp_reg  <= temp_next;
            oxy_reg   <= oxy_next;
        end
    end

endmodule

FILE: rtl/core/oxvc_ctrl.sv
// Back end: holds the reading, applies start/stop and the valve safety rule.
module oxvc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic                   wr_index,
    input  logic [15:0]            wr_data,
    input  logic                   in_valid,
    input  oxvc_pkg::parse_word_t  pw,
    output oxvc_pkg::result_word_t rw
);

    logic signed [15:0] temp_limit_reg;
    logic [15:0]        oxygen_target_reg;

    logic        active_reg, active_next;
    logic        valve_reg,  valve_next;
    logic        valid_reg,  valid_next;
    logic [23:0] amp_reg,    amp_next;
    logic [15:0] phase_reg,  phase_next;
    logic [15:0] temp_reg,   temp_next;
    logic [15:0] oxy_reg,    oxy_next;
    logic [26:0] err_reg,    err_next;
    logic        trip;

    always_comb
    begin
        active_next = active_reg;
        valve_next  = valve_reg;
        valid_next  = valid_reg;
        amp_next    = amp_reg;
        phase_next  = phase_reg;
        temp_next   = temp_reg;
        oxy_next    = oxy_reg;
        err_next    = err_reg;
        trip        = 1'b0;

        if (pw.ok)
        begin
            valid_next = 1'b1;
            amp_next   = pw.amplitude;
            phase_next = pw.phase;
            temp_next  = pw.temperature;
            oxy_next   = pw.oxygen;
            err_next   = pw.error_code;
        end

        case (pw.cmd)
            oxvc_pkg::CMD_START:
            begin
                active_next = 1'b1;
            end
            oxvc_pkg::CMD_STOP:
            begin
                active_next = 1'b0;
                valve_next  = 1'b0;
            end
            default: ;
        endcase

        if (active_next && valid_next)
        begin
            if ($signed(temp_next) > temp_limit_reg)
            begin
                valve_next  = 1'b0;
                active_next = 1'b0;
                trip        = 1'b1;
            end
            else if (err_next != '0)
            begin
                valve_next = 1'b0;
            end
            else
            begin
                valve_next = (oxy_next > oxygen_target_reg);
            end
        end
    end

    always_comb
    begin
        rw.frame_done   = pw.done;
        rw.frame_ok     = pw.ok;
        rw.valve_open   = valve_next;
        rw.system_on    = active_next;
        rw.temp_trip    = trip;
        rw.sensor_fault = (err_next != '0);
        rw.oxygen       = oxy_next;
        rw.temperature  = temp_next;
        rw.phase        = phase_next;
        rw.amplitude    = amp_next;
        rw.error_code   = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_limit_reg    <= oxvc_pkg::TEMP_LIMIT_RST;
            oxygen_target_reg <= oxvc_pkg::OXYGEN_TARGET_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                oxvc_pkg::REG_TEMP_LIMIT:    temp_limit_reg    <= wr_data;
                oxvc_pkg::REG_OXYGEN_TARGET: oxygen_target_reg <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valve_reg  <= 1'b0;
            valid_reg  <= 1'b0;
            amp_reg    <= '0;
            phase_reg  <= '0;
            temp_reg   <= '0;
            oxy_reg    <= '0;
            err_reg    <= '0;
        end
        else if (in_valid)
        begin
            active_reg <= active_next;
            valve_reg  <= valve_next;
            valid_reg  <= valid_next;
            amp_reg    <= amp_next;
            phase_reg  <= phase_next;
            temp_reg   <= temp_next;
            oxy_reg    <= oxy_next;
            err_reg    <= err_next;
        end
    end

endmodule
